### hw/rtl/sps_pkg.sv
// Shared types and constants for the sorted page binary search block.
// Store geometry, opcodes, register map and sequencer state encodings.
// No dependencies.
`default_nettype none

package sps_pkg;

    localparam int NUM_PAGES      = 16;
    localparam int WORDS_PER_PAGE = 16;

    localparam int WORD_W  = 32;
    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int SLOT_W  = $clog2(WORDS_PER_PAGE);
    localparam int OFF_W   = SLOT_W + 1;
    localparam int LH_W    = PAGE_W + 2;
    localparam int ADDR_W  = PAGE_W + SLOT_W;
    localparam int STORE_DEPTH = NUM_PAGES * WORDS_PER_PAGE;

    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    // Marks the early end of a page's content.
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic REG_FIRST_PAGE = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_DECIDE,
        S_DONE
    } t_state;

    // Which bound test the current middle page gets.
    typedef enum logic [1:0] {
        K_FP,
        K_HI,
        K_MID
    } t_kind;

endpackage

`default_nettype wire

### hw/rtl/sps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the page store.
`default_nettype none

module sps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sorted_page_binary_search.sv
// Top level of the sorted page binary search block: sequencer, register port
// and output register. Depends on sps_pkg and sps_ram (page store).
`default_nettype none

//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready       | opcode, page_sel, slot_sel,
//          |           |                               | word_value, range_low, range_high
//  out     | output    | o_out_valid / i_out_ready     | found, page_valid, page_index,
//          |           |                               | word_offset
//  cfg     | input     | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  One item at a time. A write stores its word on acceptance. A search checks the
//  range (an empty one ends it at once), then per probe (up to log2(NUM_PAGES)+1)
//  picks the middle page, scans the lower neighbor or first page (words read up to
//  the end marker, at most WORDS_PER_PAGE), then fetches the upper neighbor and
//  decides, or decides after a first-page scan; last it scans the chosen page.
//  Reset clears control state only.
//  A result waits in the output register; the sequencer holds in its done state
//  only while that register is still full.

module sorted_page_binary_search (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_opcode,
    input  wire logic [sps_pkg::PAGE_W-1:0]   i_page_sel,
    input  wire logic [sps_pkg::SLOT_W-1:0]   i_slot_sel,
    input  wire logic signed [sps_pkg::WORD_W-1:0] i_word_value,
    input  wire logic [sps_pkg::PAGE_W-1:0]   i_range_low,
    input  wire logic [sps_pkg::PAGE_W-1:0]   i_range_high,

    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_found,
    output logic                              o_page_valid,
    output logic [sps_pkg::PAGE_W-1:0]        o_page_index,
    output logic [sps_pkg::OFF_W-1:0]         o_word_offset,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sps_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [sps_pkg::PDATA_W-1:0]  pwdata,
    output logic [sps_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    import sps_pkg::*;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    logic [PAGE_W-1:0]        r_first_page;
    logic [LH_W-1:0]          r_lo, n_lo, r_hi, n_hi;
    logic [PAGE_W-1:0]        r_mid, n_mid;
    logic signed [WORD_W-1:0] r_key, n_key;
    logic signed [WORD_W-1:0] r_last, n_last;
    logic signed [WORD_W-1:0] r_upper, n_upper;

    logic [PAGE_W-1:0]        r_scan_page, n_scan_page;
    logic                     r_scan_final, n_scan_final;
    logic [OFF_W-1:0]         r_iss, n_iss;
    logic                     r_dv, n_dv;
    logic [OFF_W-1:0]         r_dslot, n_dslot;

    logic                     r_res_found, n_res_found;
    logic                     r_res_pvalid, n_res_pvalid;
    logic [PAGE_W-1:0]        r_res_page, n_res_page;
    logic [OFF_W-1:0]         r_res_off, n_res_off;

    logic                     r_out_valid, n_out_valid;
    logic                     r_o_found, r_o_pvalid;
    logic [PAGE_W-1:0]        r_o_page;
    logic [OFF_W-1:0]         r_o_off;
    logic                     out_load;

    logic                     ram_we;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [WORD_W-1:0]        rd_data;
    logic signed [WORD_W-1:0] rd_word;
    logic [SLOT_W-1:0]        rd_slot;

    logic [LH_W:0]            lh_sum;
    logic [PAGE_W-1:0]        mid_c;
    logic                     last_slot;
    logic                     above, below;
    logic                     cfg_wr;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FIRST_PAGE);
    assign prdata = (paddr[2] == REG_FIRST_PAGE)
                  ? {{(PDATA_W-PAGE_W){1'b0}}, r_first_page} : '0;

    // ---------------------------------------------------------------- store
    assign ram_we  = i_in_valid && o_in_ready && (i_opcode == OP_WRITE);
    assign rd_slot = (r_state == S_SCAN) ? r_iss[SLOT_W-1:0] : '0;
    assign rd_addr = {r_scan_page, rd_slot};
    assign rd_word = $signed(rd_data);

    sps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({i_page_sel, i_slot_sel}),
        .i_wdata (i_word_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // ---------------------------------------------------------------- sequencer
    assign o_in_ready = (r_state == S_IDLE);
    assign lh_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_c      = lh_sum[PAGE_W:1];
    assign last_slot  = (r_dslot == OFF_W'(WORDS_PER_PAGE - 1));
    assign above      = (r_mid == '0) || (r_key > r_last);
    assign below      = (r_key < r_upper);

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_key        = r_key;
        n_last       = r_last;
        n_upper      = r_upper;
        n_scan_page  = r_scan_page;
        n_scan_final = r_scan_final;
        n_iss        = r_iss;
        n_dv         = r_dv;
        n_dslot      = r_dslot;
        n_res_found  = r_res_found;
        n_res_pvalid = r_res_pvalid;
        n_res_page   = r_res_page;
        n_res_off    = r_res_off;
        rd_en        = 1'b0;
        out_load     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key = i_word_value;
                    if (i_opcode == OP_WRITE) begin
                        n_res_found  = 1'b0;
                        n_res_pvalid = 1'b0;
                        n_res_page   = '0;
                        n_res_off    = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_lo    = {2'b00, i_range_low};
                        n_hi    = {2'b00, i_range_high};
                        n_state = S_CHECK;
                    end
                end
            end

            S_CHECK: begin
                if ($signed(r_lo) > $signed(r_hi)) begin
                    n_res_found  = 1'b0;
                    n_res_pvalid = 1'b0;
                    n_res_page   = '0;
                    n_res_off    = '0;
                    n_state      = S_DONE;
                end else begin
                    n_mid        = mid_c;
                    n_iss        = '0;
                    n_dv         = 1'b0;
                    n_last       = WORD_MIN;
                    n_scan_final = 1'b0;
                    if (mid_c == r_first_page) begin
                        n_kind      = K_FP;
                        n_scan_page = mid_c;
                        n_state     = S_SCAN;
                    end else if ({2'b00, mid_c} == r_hi) begin
                        n_kind      = K_HI;
                        n_scan_page = mid_c;
                        n_state     = S_RD_ISSUE;
                    end else begin
                        n_kind = K_MID;
                        if (mid_c == '0) begin
                            // no page below: go straight to the upper neighbor
                            n_scan_page = mid_c + 1'b1;
                            n_state     = S_RD_ISSUE;
                        end else begin
                            n_scan_page = mid_c - 1'b1;
                            n_state     = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                // issue the next slot while checking the one that just came back
                if (r_iss < OFF_W'(WORDS_PER_PAGE)) begin
                    rd_en   = 1'b1;
                    n_iss   = r_iss + 1'b1;
                    n_dv    = 1'b1;
                    n_dslot = r_iss;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    if (!r_scan_final) begin
                        if (rd_word != WORD_MIN) begin
                            n_last = rd_word;
                        end
                        if (rd_word == WORD_MIN || last_slot) begin
                            if (r_kind == K_FP) begin
                                n_state = S_DECIDE;
                            end else begin
                                n_scan_page = r_mid + 1'b1;
                                n_state     = S_RD_ISSUE;
                            end
                        end
                    end else begin
                        priority if (rd_word == WORD_MIN) begin
                            n_res_found = 1'b0;
                            n_res_off   = r_dslot;
                            n_state     = S_DONE;
                        end else if (rd_word == r_key) begin
                            n_res_found = 1'b1;
                            n_res_off   = r_dslot;
                            n_state     = S_DONE;
                        end else if (rd_word > r_key) begin
                            n_res_found = 1'b0;
                            n_res_off   = r_dslot;
                            n_state     = S_DONE;
                        end else if (last_slot) begin
                            n_res_found = 1'b0;
                            n_res_off   = OFF_W'(WORDS_PER_PAGE);
                            n_state     = S_DONE;
                        end else begin
                            // advance to the next slot
                        end
                    end
                end
            end

            S_RD_ISSUE: begin
                rd_en   = 1'b1;
                n_state = S_RD_WAIT;
            end

            S_RD_WAIT: begin
                n_upper = rd_word;
                n_state = S_DECIDE;
            end

            S_DECIDE: begin
                n_state = S_CHECK;
                unique case (r_kind)
                    K_FP: begin
                        if (r_key <= r_last || {2'b00, r_first_page} == r_hi) begin
                            n_state = S_SCAN;
                        end else begin
                            n_lo = {2'b00, r_mid} + 1'b1;
                        end
                    end
                    K_HI: begin
                        if (r_key >= r_upper) begin
                            n_state = S_SCAN;
                        end else begin
                            n_hi = {2'b00, r_mid} - 1'b1;
                        end
                    end
                    default: begin
                        if (above && below) begin
                            n_state = S_SCAN;
                        end else if (!below) begin
                            n_lo = {2'b00, r_mid} + 1'b1;
                        end else begin
                            n_hi = {2'b00, r_mid} - 1'b1;
                        end
                    end
                endcase
                if (n_state == S_SCAN) begin
                    // page chosen: scan it for the key
                    n_res_pvalid = 1'b1;
                    n_res_page   = r_mid;
                    n_scan_page  = r_mid;
                    n_scan_final = 1'b1;
                    n_iss        = '0;
                    n_dv         = 1'b0;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dv         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_first_page <= '0;
        end else begin
            r_state     <= n_state;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_first_page <= pwdata[PAGE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_key        <= n_key;
        r_last       <= n_last;
        r_upper      <= n_upper;
        r_scan_page  <= n_scan_page;
        r_scan_final <= n_scan_final;
        r_iss        <= n_iss;
        r_dslot      <= n_dslot;
        r_res_found  <= n_res_found;
        r_res_pvalid <= n_res_pvalid;
        r_res_page   <= n_res_page;
        r_res_off    <= n_res_off;
        if (out_load) begin
            r_o_found  <= r_res_found;
            r_o_pvalid <= r_res_pvalid;
            r_o_page   <= r_res_page;
            r_o_off    <= r_res_off;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_o_found;
    assign o_page_valid  = r_o_pvalid;
    assign o_page_index  = r_o_page;
    assign o_word_offset = r_o_off;

endmodule

`default_nettype wire
